/* hw/rtl/nucleotide_block_packer_macros.svh */
// Assertion macros shared by the nucleotide block packer RTL.
`ifndef NUCLEOTIDE_BLOCK_PACKER_MACROS_SVH
`define NUCLEOTIDE_BLOCK_PACKER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define NBP_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nbp check failed");
// Next-cycle implication, disabled during reset.
`define NBP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nbp check failed");
`else
`define NBP_ASSERT_IMPLY(lbl, ante, cons)
`define NBP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/nbp_pkg.sv */
// Types and constants shared by the nucleotide block packer.
`timescale 1ns / 1ps
package nbp_pkg;

  localparam int unsigned BlockChars = 32;
  localparam int unsigned SlotWidth  = $clog2(BlockChars);

  // Two-bit nucleotide codes.
  localparam logic [1:0] CodeA = 2'd0;
  localparam logic [1:0] CodeC = 2'd1;
  localparam logic [1:0] CodeG = 2'd2;
  localparam logic [1:0] CodeT = 2'd3;

  // Upper case ASCII letters that the mapper recognises.
  localparam logic [7:0] AsciiA = 8'h41;
  localparam logic [7:0] AsciiC = 8'h43;
  localparam logic [7:0] AsciiG = 8'h47;
  localparam logic [7:0] AsciiN = 8'h4E;
  localparam logic [7:0] AsciiT = 8'h54;
  localparam logic [7:0] AsciiU = 8'h55;
  localparam logic [7:0] AsciiX = 8'h58;

  // Lower case range and the offset that folds it to upper case.
  localparam logic [7:0] AsciiLowA  = 8'h61;
  localparam logic [7:0] AsciiLowZ  = 8'h7A;
  localparam logic [7:0] CaseOffset = 8'h20;

  // Result of mapping one character.
  typedef struct packed {
    logic [1:0] code;
    logic       flag;
    logic       bad;
  } map_t;

endpackage

/* hw/rtl/nbp_char_map.sv */
// Character to two-bit code mapper of the nucleotide block packer.
`timescale 1ns / 1ps
module nbp_char_map (
  input  logic [7:0]   character,
  output nbp_pkg::map_t map
);

  logic [7:0] upper;

  // Fold lower case letters onto upper case before decoding.
  always_comb begin
    if (character >= nbp_pkg::AsciiLowA && character <= nbp_pkg::AsciiLowZ) begin
      upper = character - nbp_pkg::CaseOffset;
    end else begin
      upper = character;
    end
  end

  always_comb begin
    map.code = nbp_pkg::CodeA;
    map.flag = 1'b0;
    map.bad  = 1'b0;
    unique case (upper)
      nbp_pkg::AsciiA: map.code = nbp_pkg::CodeA;
      nbp_pkg::AsciiC: map.code = nbp_pkg::CodeC;
      nbp_pkg::AsciiG: map.code = nbp_pkg::CodeG;
      nbp_pkg::AsciiT,
      nbp_pkg::AsciiU: map.code = nbp_pkg::CodeT;
      nbp_pkg::AsciiN: begin
        map.code = nbp_pkg::CodeA;
        map.flag = 1'b1;
      end
      nbp_pkg::AsciiX: begin
        map.code = nbp_pkg::CodeT;
        map.flag = 1'b1;
      end
      default: begin
        // Anything unrecognised is read as N and counted.
        map.code = nbp_pkg::CodeA;
        map.flag = 1'b1;
        map.bad  = 1'b1;
      end
    endcase
  end

endmodule

/* hw/rtl/nucleotide_block_packer.sv */
// Top level of the nucleotide block packer.
`timescale 1ns / 1ps
// The packer takes one sequence character per word on the character channel and
// packs nucleotides in blocks of 32. Lower case is folded to upper case and U is
// read as T; A, C, G and T become codes 0 to 3, N becomes code 0 with its flag
// set, and X becomes code 3 with its flag set. Any other byte, including bytes of
// 128 and above, is read as N and raises a bad-character count that saturates at
// its maximum. After the 32nd character of a block one word appears on the result
// channel: high_word holds the codes of characters 16 to 31, low_word those of
// characters 0 to 15 (earliest character in the lowest bits), flag_word one flag
// bit per character, and bad_total the count so far, this block included. A
// partial block produces nothing and is discarded by reset. The block accepts one
// character every cycle while char_stall is low: a character is registered on
// entry and is then mapped and shifted into the packing registers, and the
// result register is loaded as the last character of a block leaves the entry
// register. The result register holds a finished block while the next one is being
// filled, and the character channel stalls only when the entry register holds the
// last character of a block and the result register is still waiting to be taken.
`include "nucleotide_block_packer_macros.svh"
module nucleotide_block_packer (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_stall,
  input  logic [7:0]  character,
  output logic        word_valid,
  input  logic        word_stall,
  output logic [31:0] high_word,
  output logic [31:0] low_word,
  output logic [31:0] flag_word,
  output logic [31:0] bad_total
);

  // Entry register.
  logic       held_valid;
  logic [7:0] held_char;

  // Packing state.
  logic [63:0]                    code_shift;
  logic [31:0]                    flag_shift;
  logic [nbp_pkg::SlotWidth-1:0]  slot_count;
  logic [31:0]                    bad_count;

  logic [63:0]   code_shift_next;
  logic [31:0]   flag_shift_next;
  logic [31:0]   bad_count_next;
  nbp_pkg::map_t map;
  logic          last_slot;
  logic          advance;

  nbp_char_map u_map (
    .character (held_char),
    .map       (map)
  );

  // The held character may move on unless it closes a block whose result
  // cannot yet be written because the previous one is still stalled.
  assign last_slot  = (slot_count == nbp_pkg::SlotWidth'(nbp_pkg::BlockChars - 1));
  assign advance    = held_valid && !(last_slot && word_valid && word_stall);
  assign char_stall = held_valid && !advance;

  // New codes enter at the top and move towards bit 0, so that after a full
  // block the earliest character sits in the lowest bits.
  assign code_shift_next = {map.code, code_shift[63:2]};
  assign flag_shift_next = {map.flag, flag_shift[31:1]};

  // The bad-character count sticks at all ones.
  always_comb begin
    if (map.bad && bad_count != 32'hFFFF_FFFF) begin
      bad_count_next = bad_count + 32'd1;
    end else begin
      bad_count_next = bad_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (char_valid && !char_stall) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && !char_stall) begin
      held_char <= character;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_shift <= '0;
      flag_shift <= '0;
      slot_count <= '0;
      bad_count  <= '0;
    end else if (advance) begin
      slot_count <= slot_count + 1'b1;
      bad_count  <= bad_count_next;
      if (last_slot) begin
        code_shift <= '0;
        flag_shift <= '0;
      end else begin
        code_shift <= code_shift_next;
        flag_shift <= flag_shift_next;
      end
    end
  end

  // Result register: loaded when a block closes, emptied when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (advance && last_slot) begin
      word_valid <= 1'b1;
    end else if (word_valid && !word_stall) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last_slot) begin
      high_word <= code_shift_next[63:32];
      low_word  <= code_shift_next[31:0];
      flag_word <= flag_shift_next;
      bad_total <= bad_count_next;
    end
  end

  `NBP_ASSERT_NEXT(a_block_close_loads, advance && last_slot, word_valid)
  `NBP_ASSERT_NEXT(a_slot_steps, advance,
                   slot_count == nbp_pkg::SlotWidth'($past(slot_count) + 1'b1))
  `NBP_ASSERT_NEXT(a_bad_monotonic, 1'b1, bad_count >= $past(bad_count))
  `NBP_ASSERT_IMPLY(a_stall_needs_held, char_stall, held_valid && last_slot)
  `NBP_ASSERT_IMPLY(a_empty_block_clear, slot_count == '0,
                    code_shift == '0 && flag_shift == '0)

endmodule

/* tb/nucleotide_block_packer_tb.sv */
// Self-checking testbench for the nucleotide block packer, with random stalls on both channels.
`timescale 1ns / 1ps
module nucleotide_block_packer_tb;

  // The slowest correct run is roughly 1450 characters with random idling, plus the
  // long hold-off and the drain pauses. The limit sits far above that.
  localparam int unsigned CycleLimit   = 200000;
  // A result word appears once the last character of its block has left the entry
  // register, so a short settling period at the end catches any stray word.
  localparam int unsigned SettleCycles = 20;
  // Length of the deliberate hold-off on the result channel, long enough for the
  // packer to fill its result register and the next block and then stall its input.
  localparam int unsigned LongHold     = 400;
  localparam int unsigned IdlePercent  = 24;

  // Directed characters: every recognised letter in both cases, then the byte
  // extremes, the neighbours and the top of the lower case range and bytes around
  // the upper case letters, which must all be read as unrecognised.
  localparam logic [7:0] DirectedChars [24] = '{
    nbp_pkg::AsciiA, nbp_pkg::AsciiC, nbp_pkg::AsciiG, nbp_pkg::AsciiT,
    nbp_pkg::AsciiU, nbp_pkg::AsciiN, nbp_pkg::AsciiX,
    nbp_pkg::AsciiA | nbp_pkg::CaseOffset, nbp_pkg::AsciiC | nbp_pkg::CaseOffset,
    nbp_pkg::AsciiG | nbp_pkg::CaseOffset, nbp_pkg::AsciiT | nbp_pkg::CaseOffset,
    nbp_pkg::AsciiU | nbp_pkg::CaseOffset, nbp_pkg::AsciiN | nbp_pkg::CaseOffset,
    nbp_pkg::AsciiX | nbp_pkg::CaseOffset,
    8'h00, 8'hFF, 8'h80, 8'h7F, nbp_pkg::AsciiLowA - 8'd1, nbp_pkg::AsciiLowZ + 8'd1,
    nbp_pkg::AsciiLowZ, nbp_pkg::AsciiA - 8'd1, nbp_pkg::AsciiX + 8'd3,
    nbp_pkg::AsciiA + 8'd1
  };

  typedef struct packed {
    logic [31:0] high_word;
    logic [31:0] low_word;
    logic [31:0] flag_word;
    logic [31:0] bad_total;
  } block_words_t;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        char_valid = 1'b0;
  logic        char_stall;
  logic [7:0]  character  = 8'h00;
  logic        word_valid;
  logic        word_stall = 1'b0;
  logic [31:0] high_word;
  logic [31:0] low_word;
  logic [31:0] flag_word;
  logic [31:0] bad_total;

  // Characters waiting to be offered, and the blocks the packer should still emit.
  logic [7:0]   pending_chars [$];
  block_words_t expected_blocks [$];

  int unsigned offered_chars  = 0;
  int unsigned accepted_chars = 0;
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;

  // When quiet is set neither side idles at random.
  logic        quiet          = 1'b0;
  int unsigned hold_requests  = 0;
  int unsigned holds_started  = 0;
  int unsigned hold_left      = 0;

  // Our own copy of the packing state.
  logic [63:0] code_acc = '0;
  logic [31:0] flag_acc = '0;
  logic [4:0]  slot_acc = '0;
  logic [31:0] bad_acc  = '0;

  nucleotide_block_packer dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .character  (character),
    .word_valid (word_valid),
    .word_stall (word_stall),
    .high_word  (high_word),
    .low_word   (low_word),
    .flag_word  (flag_word),
    .bad_total  (bad_total)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Maps one character and shifts it into the packing state. New codes enter at the
  // top and move down, so after 32 characters the first one sits in bits 1:0. Once a
  // block is complete its words are queued and the shift registers are cleared.
  task automatic pack_character(input logic [7:0] ch);
    logic [7:0]    up;
    nbp_pkg::map_t m;
    up = ch;
    if (up >= nbp_pkg::AsciiLowA && up <= nbp_pkg::AsciiLowZ) begin
      up = up - nbp_pkg::CaseOffset;
    end
    m = '{code: nbp_pkg::CodeA, flag: 1'b0, bad: 1'b0};
    case (up)
      nbp_pkg::AsciiA: m.code = nbp_pkg::CodeA;
      nbp_pkg::AsciiC: m.code = nbp_pkg::CodeC;
      nbp_pkg::AsciiG: m.code = nbp_pkg::CodeG;
      nbp_pkg::AsciiT, nbp_pkg::AsciiU: m.code = nbp_pkg::CodeT;
      nbp_pkg::AsciiN: m.flag = 1'b1;
      nbp_pkg::AsciiX: begin
        m.code = nbp_pkg::CodeT;
        m.flag = 1'b1;
      end
      default: begin
        m.flag = 1'b1;
        m.bad  = 1'b1;
      end
    endcase
    // The count saturates rather than wrapping.
    if (m.bad && bad_acc != '1) begin
      bad_acc = bad_acc + 32'd1;
    end
    code_acc = {m.code, code_acc[63:2]};
    flag_acc = {m.flag, flag_acc[31:1]};
    slot_acc = slot_acc + 5'd1;
    if (slot_acc == '0) begin
      expected_blocks.push_back('{high_word: code_acc[63:32], low_word: code_acc[31:0],
                                  flag_word: flag_acc, bad_total: bad_acc});
      code_acc = '0;
      flag_acc = '0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %08h, got %08h", name, want, got);
      mismatches++;
    end
  endtask

  // Mostly well-formed sequence text with random case, some N, X and U, and 16 percent
  // of arbitrary bytes so that unrecognised characters turn up regularly.
  function automatic logic [7:0] random_character();
    logic [7:0]  base;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      case ($urandom_range(0, 3))
        0:       base = nbp_pkg::AsciiA;
        1:       base = nbp_pkg::AsciiC;
        2:       base = nbp_pkg::AsciiG;
        default: base = nbp_pkg::AsciiT;
      endcase
    end else if (pick < 84) begin
      case ($urandom_range(0, 2))
        0:       base = nbp_pkg::AsciiN;
        1:       base = nbp_pkg::AsciiX;
        default: base = nbp_pkg::AsciiU;
      endcase
    end else begin
      return 8'($urandom_range(0, 255));
    end
    if ($urandom_range(0, 3) == 0) begin
      base = base | nbp_pkg::CaseOffset;
    end
    return base;
  endfunction

  task automatic add_random(input int unsigned count);
    repeat (count) pending_chars.push_back(random_character());
  endtask

  // Waits until every queued character has been taken and every block has come out.
  // It samples on the falling edge so that it never races the monitor.
  task automatic drain();
    while (pending_chars.size() != 0 || accepted_chars != offered_chars ||
           expected_blocks.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Character driver. A word that has been offered stays on the port until the
  // monitor has seen it accepted; otherwise the next one is offered unless this
  // cycle is picked to idle.
  always @(negedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (char_valid && accepted_chars != offered_chars) begin
      char_valid <= 1'b1;
    end else if (pending_chars.size() != 0 &&
                 (quiet || $urandom_range(0, 99) >= IdlePercent)) begin
      character  <= pending_chars.pop_front();
      char_valid <= 1'b1;
      offered_chars++;
    end else begin
      char_valid <= 1'b0;
    end
  end

  // Result receiver. A hold-off request makes it stall for a long count of cycles;
  // otherwise it stalls at random unless the run is in a quiet stretch.
  always @(negedge clk) begin
    if (holds_started != hold_requests) begin
      hold_left = LongHold;
      holds_started++;
    end
    if (hold_left != 0) begin
      word_stall <= 1'b1;
      hold_left--;
    end else if (quiet) begin
      word_stall <= 1'b0;
    end else begin
      word_stall <= ($urandom_range(0, 99) < IdlePercent);
    end
  end

  // Monitor. The result channel is checked before the character accepted on the same
  // edge is predicted; as that character must first pass the entry register, it can
  // never belong to the word being checked.
  always @(posedge clk) begin
    block_words_t want;
    if (!rst) begin
      if (word_valid && !word_stall) begin
        if (expected_blocks.size() == 0) begin
          $error("result word arrived with no block expected");
          mismatches++;
        end else begin
          want = expected_blocks.pop_front();
          check_field("high_word", want.high_word, high_word);
          check_field("low_word", want.low_word, low_word);
          check_field("flag_word", want.flag_word, flag_word);
          check_field("bad_total", want.bad_total, bad_total);
        end
      end
      if (char_valid && !char_stall) begin
        pack_character(character);
        accepted_chars++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed letters and odd bytes, topped up to a whole block.
    foreach (DirectedChars[i]) pending_chars.push_back(DirectedChars[i]);
    add_random(8);
    add_random(400);

    // The sender pauses here until every block has been taken.
    drain();

    // The receiver holds off for a long stretch while the sender keeps offering
    // characters back to back, so the packer fills up and stalls its input. After
    // the hold-off the run carries on with no idling on either side.
    quiet = 1'b1;
    hold_requests++;
    add_random(200);
    drain();
    add_random(300);
    drain();

    quiet = 1'b0;
    add_random(500);
    drain();

    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0 && expected_blocks.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
